@@ rtl/art_pkg.sv @@
// shared types and constants for the address region table
`default_nettype none
package art_pkg;
  localparam int unsigned MaxRegions = 64;
  localparam int unsigned AddrW = 64;
  localparam int unsigned FlagW = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LASTHIT,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

@@ rtl/art_region_mem.sv @@
// region storage: one synchronous memory, start, end and flags side by side
`default_nettype none
module art_region_mem #(
  parameter int unsigned MAX_REGIONS = art_pkg::MaxRegions,
  localparam int unsigned IdxW = $clog2(MAX_REGIONS),
  localparam int unsigned RowW = 2 * art_pkg::AddrW + art_pkg::FlagW
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IdxW-1:0] wr_addr,
  input  wire logic [RowW-1:0] wr_data,
  input  wire logic [IdxW-1:0] rd_addr,
  output logic      [RowW-1:0] rd_data
);
  logic [RowW-1:0] mem [MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ rtl/address_region_table_unit.sv @@
// address region table: sorted non-overlapping regions with insert, find and clear
//
// s_axis carries one request: opcode, range bounds, flags and a lookup address.
// m_axis carries one response per request: status, matched region, position
// and the number of regions held afterwards.
// Regions live in one single-port-read memory with a registered read, so
// every table access waits for its read data before the entry is used. Work
// done between acceptance and a valid response, with N regions held:
//   clear, no-op and an insert refused for an empty range or a full table:
//     straight to the response; find: the last-hit entry is checked if
//     valid, then, failing it, a scan from position 0 to a hit or the end
//   insert at position p: a scan of the entries up to p, a shift up of the
//     N-p entries above it (none when appended at the end) and a write
// Only one request is worked on at a time; the response sits in an output
// register and a new request is taken as soon as it has been handed over, or
// in the same cycle it leaves.
// Reset empties the table and forgets the last hit; memory contents are left
// as they are and are never read before being written.
// If m_axis_tready is low the response is held and no new request is taken.
`default_nettype none
module address_region_table_unit #(
  parameter int unsigned MAX_REGIONS = art_pkg::MaxRegions
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[1:0], range_start[65:2], range_end[129:66], range_flags[133:130],
  // lookup_address[197:134], zero fill [199:198]
  input  wire logic [199:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], found_start[65:2], found_end[129:66], found_flags[133:130],
  // entry_position[139:134], entries_in_use[146:140], zero fill [151:147]
  output logic      [151:0] m_axis_tdata
);
  localparam int unsigned AW = art_pkg::AddrW;
  localparam int unsigned FW = art_pkg::FlagW;
  localparam int unsigned IdxW = $clog2(MAX_REGIONS);
  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned RowW = 2 * AW + FW;

  // request register
  art_pkg::opcode_t op;
  logic [AW-1:0]    rs, re, la;
  logic [FW-1:0]    rf;

  art_pkg::state_t state, state_next;
  logic [CntW-1:0] total;
  logic [IdxW-1:0] lh_idx;
  logic            lh_valid;
  logic [CntW-1:0] idx;
  logic            rd_wait; // read in flight (for idx, idx-1 or the last hit)

  // response register
  art_pkg::status_t o_status;
  logic [AW-1:0]    o_start, o_end;
  logic [FW-1:0]    o_flags;
  logic [5:0]       o_pos;
  logic [6:0]       o_total;
  logic             o_valid;

  logic            wr_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [RowW-1:0] wr_data, rd_data;
  logic [AW-1:0]   q_start, q_end;
  logic [FW-1:0]   q_flags;

  assign q_flags = rd_data[RowW-1 -: FW];
  assign q_end   = rd_data[AW +: AW];
  assign q_start = rd_data[AW-1:0];

  art_region_mem #(.MAX_REGIONS(MAX_REGIONS)) u_mem (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  logic take;
  assign s_axis_tready = (state == art_pkg::S_IDLE) && (!o_valid || m_axis_tready);
  assign take = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata = {5'd0, o_total, o_pos, o_flags, o_end, o_start, o_status};

  logic [IdxW-1:0] idx_lo;
  logic [IdxW-1:0] idx_m1;
  logic            hit;
  logic [CntW-1:0] ins_pos; // insert position found by the scan
  assign idx_lo = idx[IdxW-1:0];
  assign idx_m1 = idx_lo - IdxW'(1);
  assign hit = (q_start <= la) && (la < q_end);

  // prev_ok: entry just below the insert point ends at or before the new start
  logic          prev_ok;

  always_comb begin
    state_next = state;
    rd_addr = idx_lo;
    wr_en = 1'b0;
    wr_addr = idx_lo;
    wr_data = {q_flags, q_end, q_start};
    unique case (state)
      art_pkg::S_IDLE: begin
        if (take) begin
          unique case (art_pkg::opcode_t'(s_axis_tdata[1:0]))
            art_pkg::OP_INSERT: begin
              if (s_axis_tdata[65:2] >= s_axis_tdata[129:66]) begin
                state_next = art_pkg::S_DONE;
              end else if (total >= CntW'(MAX_REGIONS)) begin
                state_next = art_pkg::S_DONE;
              end else begin
                state_next = art_pkg::S_SCAN;
              end
            end
            art_pkg::OP_FIND: begin
              state_next = (lh_valid && CntW'(lh_idx) < total) ? art_pkg::S_LASTHIT
                                                                : art_pkg::S_SCAN;
            end
            art_pkg::OP_CLEAR: state_next = art_pkg::S_DONE;
            art_pkg::OP_NOP: state_next = art_pkg::S_DONE;
            default: state_next = art_pkg::S_DONE;
          endcase
        end
      end
      art_pkg::S_LASTHIT: begin
        rd_addr = lh_idx;
        if (rd_wait) state_next = hit ? art_pkg::S_DONE : art_pkg::S_SCAN;
      end
      art_pkg::S_SCAN: begin
        if (!rd_wait) begin
          if (idx >= total) begin
            if (op == art_pkg::OP_FIND || !prev_ok) begin
              state_next = art_pkg::S_DONE;
            end else begin
              state_next = (idx == total) ? art_pkg::S_WRITE : art_pkg::S_SHIFT;
            end
          end
        end else if (op == art_pkg::OP_FIND) begin
          if (hit) state_next = art_pkg::S_DONE;
        end else if (q_start > rs) begin
          state_next = (!prev_ok || re > q_start) ? art_pkg::S_DONE : art_pkg::S_SHIFT;
        end
      end
      art_pkg::S_SHIFT: begin
        rd_addr = idx_m1;
        wr_addr = idx_lo;
        wr_en = rd_wait;
        if (rd_wait && idx - CntW'(1) == ins_pos) state_next = art_pkg::S_WRITE;
      end
      art_pkg::S_WRITE: begin
        wr_en = 1'b1;
        wr_addr = idx_lo;
        wr_data = {rf, re, rs};
        state_next = art_pkg::S_DONE;
      end
      art_pkg::S_DONE: begin
        if (!o_valid) state_next = art_pkg::S_IDLE;
      end
      default: state_next = art_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= art_pkg::S_IDLE;
      total <= '0;
      lh_idx <= '0;
      lh_valid <= 1'b0;
      o_valid <= 1'b0;
      rd_wait <= 1'b0;
    end else begin
      state <= state_next;
      if (o_valid && m_axis_tready) o_valid <= 1'b0;
      unique case (state)
        art_pkg::S_IDLE: begin
          if (take) begin
            op <= art_pkg::opcode_t'(s_axis_tdata[1:0]);
            rs <= s_axis_tdata[65:2];
            re <= s_axis_tdata[129:66];
            rf <= s_axis_tdata[133:130];
            la <= s_axis_tdata[197:134];
            o_start <= '0;
            o_end <= '0;
            o_flags <= '0;
            o_pos <= '0;
            idx <= '0;
            rd_wait <= 1'b0;
            prev_ok <= 1'b1;
            unique case (art_pkg::opcode_t'(s_axis_tdata[1:0]))
              art_pkg::OP_INSERT: begin
                if (s_axis_tdata[65:2] >= s_axis_tdata[129:66]) begin
                  o_status <= art_pkg::ST_BAD_RANGE;
                end else if (total >= CntW'(MAX_REGIONS)) begin
                  o_status <= art_pkg::ST_FULL;
                end else begin
                  o_status <= art_pkg::ST_OK;
                end
              end
              art_pkg::OP_FIND: o_status <= art_pkg::ST_OK;
              art_pkg::OP_CLEAR: begin
                o_status <= art_pkg::ST_OK;
                total <= '0;
                lh_idx <= '0;
                lh_valid <= 1'b0;
              end
              art_pkg::OP_NOP: o_status <= art_pkg::ST_OK;
              default: o_status <= art_pkg::ST_OK;
            endcase
          end
        end
        art_pkg::S_LASTHIT: begin
          if (!rd_wait) begin
            rd_wait <= 1'b1;
          end else begin
            rd_wait <= 1'b0;
            if (hit) begin
              o_start <= q_start;
              o_end <= q_end;
              o_flags <= q_flags;
              o_pos <= 6'(lh_idx);
            end
          end
        end
        art_pkg::S_SCAN: begin
          if (!rd_wait) begin
            if (idx >= total) begin
              // ran off the end
              if (op == art_pkg::OP_FIND) begin
                o_status <= art_pkg::ST_NOT_FOUND;
              end else if (!prev_ok) begin
                o_status <= art_pkg::ST_BAD_RANGE;
              end else begin
                ins_pos <= idx;
                idx <= total;
              end
            end else begin
              rd_wait <= 1'b1;
            end
          end else begin
            rd_wait <= 1'b0;
            if (op == art_pkg::OP_FIND) begin
              if (hit) begin
                o_start <= q_start;
                o_end <= q_end;
                o_flags <= q_flags;
                o_pos <= 6'(idx);
                lh_idx <= idx_lo;
                lh_valid <= 1'b1;
              end else begin
                idx <= idx + CntW'(1);
              end
            end else if (q_start <= rs) begin
              prev_ok <= !(q_end > rs);
              idx <= idx + CntW'(1);
            end else if (!prev_ok || re > q_start) begin
              o_status <= art_pkg::ST_BAD_RANGE;
            end else begin
              ins_pos <= idx;
              idx <= total;
            end
          end
        end
        art_pkg::S_SHIFT: begin
          // copy entry idx-1 up to idx, a read and then a write for each entry
          if (!rd_wait) begin
            rd_wait <= 1'b1;
          end else begin
            rd_wait <= 1'b0;
            idx <= idx - CntW'(1);
          end
        end
        art_pkg::S_WRITE: begin
          total <= total + CntW'(1);
          o_pos <= 6'(ins_pos);
          if (lh_valid && CntW'(lh_idx) >= ins_pos) lh_idx <= lh_idx + IdxW'(1);
        end
        art_pkg::S_DONE: begin
          if (!o_valid) begin
            o_valid <= 1'b1;
            o_total <= 7'(total);
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) total <= CntW'(MAX_REGIONS))
    else $error("region count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    lh_valid |-> CntW'(lh_idx) < total || total == '0)
    else $error("last hit beyond table");
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == art_pkg::S_SHIFT || state == art_pkg::S_WRITE)
    else $error("memory write outside insert");
  assert property (@(posedge clk) disable iff (rst)
    take |=> !s_axis_tready)
    else $error("second request taken while busy");
endmodule
`default_nettype wire
